FILE: design/rpn_pkg.sv
// Package for the RPN stack calculator: payload structs, command codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int DIV_STEPS       = 48;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam logic [3:0] FUNC_PUSH     = 4'd0;
    localparam logic [3:0] FUNC_CLEAR    = 4'd1;
    localparam logic [3:0] FUNC_PEEK     = 4'd2;
    localparam logic [3:0] FUNC_DUP      = 4'd3;
    localparam logic [3:0] FUNC_SWAP     = 4'd4;
    localparam logic [3:0] FUNC_ADD      = 4'd5;
    localparam logic [3:0] FUNC_SUB      = 4'd6;
    localparam logic [3:0] FUNC_MUL      = 4'd7;
    localparam logic [3:0] FUNC_DIV      = 4'd8;
    localparam logic [3:0] FUNC_MOD      = 4'd9;
    localparam logic [3:0] FUNC_POP_SHOW = 4'd10;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand;
    } in_item_t;

    typedef struct packed {
        logic               shows_value;
        logic signed [31:0] shown_value;
        logic               underflow;
        logic               overflow;
        logic               divide_by_zero;
        logic               unknown_command;
    } out_item_t;

    typedef enum logic [1:0] {
        SRC_OPND,
        SRC_A,
        SRC_B,
        SRC_R
    } push_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_A,
        S_WAIT_A,
        S_CHECK_A,
        S_POP_B,
        S_WAIT_B,
        S_EXEC,
        S_MUL_FIX,
        S_DIV_RUN,
        S_DIV_FIX,
        S_PUSH_1,
        S_PUSH_2,
        S_PEEK_RD,
        S_PEEK_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      start;
        logic      pop;
        logic      cap_a;
        logic      cap_b;
        logic      cap_show;
        logic      show_a;
        logic      clear_depth;
        logic      set_under;
        logic      set_divz;
        logic      set_unk;
        logic      push;
        push_src_t push_sel;
        logic      alu_exec;
        logic      alu_sub;
        logic      mul_exec;
        logic      mul_fix;
        logic      div_start;
        logic      div_mod;
        logic      div_step;
        logic      div_fix;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic depth_zero;
        logic a_zero;
        logic a_int_zero;
        logic div_last;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [16:0] trunc16(input logic signed [31:0] x);
        logic signed [16:0] fl;
        fl = {x[31], x[31:16]};
        if (x[31] && (x[15:0] != 16'd0))
            fl = fl + 17'sd1;
        return fl;
    endfunction

endpackage

FILE: design/rpn_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: design/rpn_ctrl.sv
// Controller state machine of the RPN stack calculator.
// Depends on rpn_pkg; drives rpn_datapath through dp_cmd_t.
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] in_func,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [3:0] func_reg;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            func_reg <= in_func;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                case (func_reg)
                    FUNC_PUSH: state_next = S_PUSH_1;
                    FUNC_PEEK: state_next = status.depth_zero ? S_DONE : S_PEEK_RD;
                    FUNC_CLEAR, FUNC_DUP, FUNC_SWAP, FUNC_ADD, FUNC_SUB, FUNC_MUL,
                    FUNC_DIV, FUNC_MOD, FUNC_POP_SHOW:
                        state_next = S_POP_A;
                    default:   state_next = S_DONE;
                endcase
            S_POP_A:   state_next = S_WAIT_A;
            S_WAIT_A:  state_next = S_CHECK_A;
            S_CHECK_A:
                case (func_reg)
                    FUNC_CLEAR, FUNC_POP_SHOW: state_next = S_DONE;
                    FUNC_DUP:                  state_next = S_PUSH_1;
                    FUNC_DIV: state_next = status.a_zero ? S_DONE : S_POP_B;
                    FUNC_MOD: state_next = status.a_int_zero ? S_DONE : S_POP_B;
                    default:                   state_next = S_POP_B;
                endcase
            S_POP_B:   state_next = S_WAIT_B;
            S_WAIT_B:  state_next = S_EXEC;
            S_EXEC:
                case (func_reg)
                    FUNC_MUL:           state_next = S_MUL_FIX;
                    FUNC_DIV, FUNC_MOD: state_next = S_DIV_RUN;
                    default:            state_next = S_PUSH_1;
                endcase
            S_MUL_FIX: state_next = S_PUSH_1;
            S_DIV_RUN:
                if (status.div_last)
                    state_next = S_DIV_FIX;
            S_DIV_FIX: state_next = S_PUSH_1;
            S_PUSH_1:
                state_next = (func_reg == FUNC_DUP || func_reg == FUNC_SWAP) ? S_PUSH_2
                                                                             : S_DONE;
            S_PUSH_2:    state_next = S_DONE;
            S_PEEK_RD:   state_next = S_PEEK_WAIT;
            S_PEEK_WAIT: state_next = S_DONE;
            S_DONE:
                if (status.out_free)
                    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.push_sel = SRC_R;
        cmd.alu_sub  = (func_reg == FUNC_SUB);
        cmd.div_mod  = (func_reg == FUNC_MOD);
        unique case (state_reg)
            S_IDLE:
                cmd.start = accept;
            S_DISPATCH:
                case (func_reg)
                    FUNC_PEEK: cmd.set_under = status.depth_zero;
                    FUNC_PUSH, FUNC_CLEAR, FUNC_DUP, FUNC_SWAP, FUNC_ADD, FUNC_SUB,
                    FUNC_MUL, FUNC_DIV, FUNC_MOD, FUNC_POP_SHOW:
                        cmd.set_unk = 1'b0;
                    default:   cmd.set_unk = 1'b1;
                endcase
            S_POP_A, S_POP_B:
                cmd.pop = 1'b1;
            S_WAIT_A:
                cmd.cap_a = 1'b1;
            S_CHECK_A:
                case (func_reg)
                    FUNC_CLEAR:
                    begin
                        cmd.show_a      = 1'b1;
                        cmd.clear_depth = 1'b1;
                    end
                    FUNC_POP_SHOW: cmd.show_a   = 1'b1;
                    FUNC_DIV:      cmd.set_divz = status.a_zero;
                    FUNC_MOD:      cmd.set_divz = status.a_int_zero;
                    default:       cmd.show_a   = 1'b0;
                endcase
            S_WAIT_B:
                cmd.cap_b = 1'b1;
            S_EXEC:
                case (func_reg)
                    FUNC_ADD, FUNC_SUB: cmd.alu_exec  = 1'b1;
                    FUNC_MUL:           cmd.mul_exec  = 1'b1;
                    FUNC_DIV, FUNC_MOD: cmd.div_start = 1'b1;
                    default:            cmd.alu_exec  = 1'b0;
                endcase
            S_MUL_FIX:
                cmd.mul_fix = 1'b1;
            S_DIV_RUN:
                cmd.div_step = 1'b1;
            S_DIV_FIX:
                cmd.div_fix = 1'b1;
            S_PUSH_1:
            begin
                cmd.push = 1'b1;
                case (func_reg)
                    FUNC_PUSH:          cmd.push_sel = SRC_OPND;
                    FUNC_DUP, FUNC_SWAP: cmd.push_sel = SRC_A;
                    default:            cmd.push_sel = SRC_R;
                endcase
            end
            S_PUSH_2:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = (func_reg == FUNC_SWAP) ? SRC_B : SRC_A;
            end
            S_PEEK_RD:
                cmd.pop = 1'b0;
            S_PEEK_WAIT:
                cmd.cap_show = 1'b1;
            S_DONE:
                cmd.out_load = status.out_free;
            default:
                cmd.start = 1'b0;
        endcase
    end

endmodule

FILE: design/rpn_datapath.sv
// Datapath of the RPN stack calculator: stack RAM, depth counter, operand
// registers, saturating add/sub/mul, radix-2 divider and output register.
// Depends on rpn_pkg and rpn_ram.
module rpn_datapath
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic signed [31:0] in_operand,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]      depth_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic signed [31:0] operand_reg;
    logic signed [31:0] a_reg, b_reg, r_reg;
    logic               pend_zero_reg;
    logic signed [63:0] prod_reg;
    logic [32:0]        rem_reg;
    logic [47:0]        quo_reg;
    logic [31:0]        dmag_reg;
    logic               nsign_reg, qneg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic               shows_reg, under_reg, over_reg, divz_reg, unk_reg;
    logic signed [31:0] shown_reg;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        wdata, rdata;
    logic               full;

    logic signed [32:0] sum;
    logic signed [47:0] mul_shift;
    logic signed [31:0] mul_sat, add_sat;
    logic signed [47:0] div_n;
    logic signed [31:0] div_d;
    logic signed [16:0] ta, tb;
    logic [32:0]        trial;
    logic               qbit;
    logic signed [31:0] div_res;
    logic signed [15:0] rem_s;

    assign full  = (depth_reg == DW'(STACK_DEPTH));
    assign raddr = AW'(depth_reg - DW'(1));
    assign waddr = depth_reg[AW-1:0];
    assign we    = cmd.push && !full;

    always_comb
    begin
        case (cmd.push_sel)
            SRC_OPND: wdata = operand_reg;
            SRC_A:    wdata = a_reg;
            SRC_B:    wdata = b_reg;
            default:  wdata = r_reg;
        endcase
    end

    rpn_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign ta = trunc16(a_reg);
    assign tb = trunc16(b_reg);

    assign sum     = cmd.alu_sub ? (33'(b_reg) - 33'(a_reg)) : (33'(b_reg) + 33'(a_reg));
    assign add_sat = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                          : sum[31:0];

    assign mul_shift = prod_reg[63:16];
    assign mul_sat   = (mul_shift > 48'sh0000_7FFF_FFFF)  ? 32'sh7FFF_FFFF :
                       (mul_shift < -48'sh0000_8000_0000) ? 32'sh8000_0000 :
                                                             mul_shift[31:0];

    assign div_n = cmd.div_mod ? {{31{tb[16]}}, tb} : {b_reg, 16'd0};
    assign div_d = cmd.div_mod ? {{15{ta[16]}}, ta} : a_reg;

    assign trial = {rem_reg[31:0], quo_reg[47]};
    assign qbit  = (trial >= {1'b0, dmag_reg});

    assign rem_s = nsign_reg ? -(rem_reg[15:0]) : rem_reg[15:0];

    always_comb
    begin
        if (cmd.div_mod)
            div_res = {rem_s, 16'd0};
        else if (!qneg_reg)
            div_res = (quo_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_reg[31:0];
        else
            div_res = (quo_reg > 48'h0000_8000_0000) ? 32'sh8000_0000 : -(quo_reg[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_depth)
                depth_reg <= '0;
            else if (cmd.pop && depth_reg != '0)
                depth_reg <= depth_reg - DW'(1);
            else if (we)
                depth_reg <= depth_reg + DW'(1);

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            operand_reg <= in_operand;

        if (cmd.start)
        begin
            shows_reg <= 1'b0;
            shown_reg <= '0;
            under_reg <= 1'b0;
            over_reg  <= 1'b0;
            divz_reg  <= 1'b0;
            unk_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.pop)
            begin
                pend_zero_reg <= (depth_reg == '0);
                if (depth_reg == '0)
                    under_reg <= 1'b1;
            end
            if (cmd.set_under)
                under_reg <= 1'b1;
            if (cmd.push && full)
                over_reg <= 1'b1;
            if (cmd.set_divz)
                divz_reg <= 1'b1;
            if (cmd.set_unk)
                unk_reg <= 1'b1;
            if (cmd.show_a)
            begin
                shows_reg <= 1'b1;
                shown_reg <= a_reg;
            end
            if (cmd.cap_show)
            begin
                shows_reg <= 1'b1;
                shown_reg <= rdata;
            end
        end

        if (cmd.cap_a)
            a_reg <= pend_zero_reg ? 32'sd0 : rdata;
        if (cmd.cap_b)
            b_reg <= pend_zero_reg ? 32'sd0 : rdata;

        if (cmd.alu_exec)
            r_reg <= add_sat;
        if (cmd.mul_exec)
            prod_reg <= 64'(b_reg) * 64'(a_reg);
        if (cmd.mul_fix)
            r_reg <= mul_sat;

        if (cmd.div_start)
        begin
            nsign_reg <= div_n[47];
            qneg_reg  <= div_n[47] ^ div_d[31];
            quo_reg   <= div_n[47] ? -div_n : div_n;
            dmag_reg  <= div_d[31] ? -div_d : div_d;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? (trial - {1'b0, dmag_reg}) : trial;
            quo_reg <= {quo_reg[46:0], qbit};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.div_fix)
            r_reg <= div_res;

        if (cmd.out_load)
        begin
            out_reg.shows_value     <= shows_reg;
            out_reg.shown_value     <= shown_reg;
            out_reg.underflow       <= under_reg;
            out_reg.overflow        <= over_reg;
            out_reg.divide_by_zero  <= divz_reg;
            out_reg.unknown_command <= unk_reg;
        end
    end

    assign status.depth_zero = (depth_reg == '0);
    assign status.a_zero     = (a_reg == 32'sd0);
    assign status.a_int_zero = (ta == 17'sd0);
    assign status.div_last   = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: design/rpn_stack_calculator.sv
// Each command runs its own state sequence from accept to out_valid; div and mod run the
// 48-step radix-2 divider unless the divisor is found zero; one stack RAM access per cycle.
// Throughput: one transaction at a time; the next can be taken in the same cycle as the
// result first shows on out_valid, and a stalled result holds the controller until it leaves.
// Reset: asynchronous, clears the controller, depth counter and output valid; the stack
// RAM is not cleared, since only entries below the depth are ever read.
// Top level; depends on rpn_pkg, rpn_ctrl, rpn_datapath.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rpn_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_func (in_data.func),
        .status  (status),
        .cmd     (cmd)
    );

    rpn_datapath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_valid && in_ready),
        .in_operand(in_data.operand),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
